/* rtl/gkps_pkg.sv */
`default_nettype none
package gkps_pkg;

   // Field widths
   localparam int POS_WIDTH      = 24;
   localparam int GAIN_FRAC_BITS = 24;
   localparam int DIFF_W         = POS_WIDTH + 1;
   localparam int GAIN_W         = GAIN_FRAC_BITS + 1;
   localparam int VAR_W          = 32;
   localparam int PRIOR_W        = VAR_W + 1;
   localparam int DEN_W          = PRIOR_W + 1;
   localparam int REM_W          = DEN_W + 1;
   localparam int PROD_W         = PRIOR_W + GAIN_W;
   localparam int NV_W           = PROD_W - GAIN_FRAC_BITS;
   localparam int DIV_CNT_W      = $clog2(GAIN_W + 1);
   localparam int AXES           = 3;
   localparam int TDATA_W        = ((AXES * POS_WIDTH + 7) / 8) * 8;

   // Configuration registers
   localparam int DRIFT_W     = 31;
   localparam int SENSOR_W    = 31;
   localparam int REJECT_W    = 23;
   localparam int CSR_DATA_W  = 31;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_DRIFT  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SENSOR = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REJECT = 2'd2;

   localparam logic [DRIFT_W-1:0]  DRIFT_RESET  = 31'd429497;
   localparam logic [SENSOR_W-1:0] SENSOR_RESET = 31'd17179869;
   localparam logic [REJECT_W-1:0] REJECT_RESET = 23'd3277;

   // Multiplier operand select
   localparam logic [1:0] SEL_X   = 2'd0;
   localparam logic [1:0] SEL_Y   = 2'd1;
   localparam logic [1:0] SEL_Z   = 2'd2;
   localparam logic [1:0] SEL_VAR = 2'd3;

   typedef enum logic [1:0] {
      RSP_SMOOTH  = 2'd0,
      RSP_OUTLIER = 2'd1,
      RSP_RESET   = 2'd2
   } rsp_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_DIV,
      ST_MUL,
      ST_APPLY,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic           capture;
      logic           clear;
      logic           load;
      logic           start;
      logic           mul;
      logic           apply;
      logic           write;
      logic [1:0]     sel;
      rsp_status_type status;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_reset;
      logic primed;
      logic outlier;
      logic div_busy;
      logic rsp_free;
   } dp_status_type;

endpackage
`default_nettype wire

/* rtl/gkps_div.sv */
`default_nettype none
module gkps_div
   import gkps_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [PRIOR_W-1:0] num,
   input  wire logic [DEN_W-1:0]   den,
   output logic                    busy,
   output logic [GAIN_W-1:0]       quot
);

   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 first_ff, first_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [GAIN_W-1:0]    quot_ff, quot_in;
   logic [REM_W-1:0]     trial;
   logic                 ge;

   // One quotient bit per cycle, restoring
   always_comb begin
      trial    = first_ff ? rem_ff : {rem_ff[REM_W-2:0], 1'b0};
      ge       = trial >= REM_W'(den_ff);
      cnt_in   = cnt_ff;
      first_in = first_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quot_in  = quot_ff;
      if (start) begin
         cnt_in   = DIV_CNT_W'(GAIN_W);
         first_in = 1'b1;
         rem_in   = REM_W'(num);
         den_in   = den;
         quot_in  = '0;
      end else if (cnt_ff != '0) begin
         cnt_in   = cnt_ff - DIV_CNT_W'(1);
         first_in = 1'b0;
         rem_in   = ge ? trial - REM_W'(den_ff) : trial;
         quot_in  = {quot_ff[GAIN_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      first_ff <= first_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      quot_ff  <= quot_in;
   end

   assign busy = cnt_ff != '0;
   // A zero denominator gives zero gain
   assign quot = (den_ff == '0) ? '0 : quot_ff;

endmodule
`default_nettype wire

/* rtl/gkps_datapath.sv */
`default_nettype none
module gkps_datapath
   import gkps_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [TDATA_W-1:0]     req_tdata,
   input  wire logic [0:0]             req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [TDATA_W-1:0]          rsp_tdata,
   output logic [1:0]                  rsp_tuser,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   input  wire ctrl_cmd_type           cmd,
   output dp_status_type               status
);

   logic [DRIFT_W-1:0]   drift_ff;
   logic [SENSOR_W-1:0]  sensor_ff;
   logic [REJECT_W-1:0]  reject_ff;

   logic                 is_reset_ff;
   logic [POS_WIDTH-1:0] meas_ff [AXES];
   logic [POS_WIDTH-1:0] est_ff  [AXES];
   logic [POS_WIDTH-1:0] est_in  [AXES];
   logic [VAR_W-1:0]     var_ff, var_in;
   logic                 primed_ff, primed_in;
   logic [PRIOR_W-1:0]   prior_ff;
   logic [PRIOR_W-1:0]   prior_sum;
   logic [DEN_W-1:0]     den_sum;
   logic [PROD_W-1:0]    prod_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_status_type       rsp_status_ff;
   logic [POS_WIDTH-1:0] rsp_pos_ff [AXES];

   logic [DIFF_W-1:0]    diff [AXES];
   logic [DIFF_W-1:0]    mag  [AXES];
   logic                 outlier;
   logic                 div_busy;
   logic [GAIN_W-1:0]    gain;
   logic [PRIOR_W-1:0]   mul_a;
   logic [GAIN_W-1:0]    mul_b;
   logic [DIFF_W-1:0]    mag_sel;
   logic                 neg_sel;
   logic [POS_WIDTH-1:0] est_sel;
   logic [PROD_W-1:0]    rounded;
   logic [DIFF_W-1:0]    step;
   logic [POS_WIDTH-1:0] est_upd;
   logic [NV_W-1:0]      nv;

   // Configuration writes; indexes beyond the list fall through
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         drift_ff  <= DRIFT_RESET;
         sensor_ff <= SENSOR_RESET;
         reject_ff <= REJECT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DRIFT:  drift_ff  <= DRIFT_W'(csr_data);
            CSR_SENSOR: sensor_ff <= SENSOR_W'(csr_data);
            CSR_REJECT: reject_ff <= REJECT_W'(csr_data);
            default: ;
         endcase
      end
   end

   // Per-axis innovation, magnitude and gate
   always_comb begin
      outlier = 1'b0;
      for (int i = 0; i < AXES; i++) begin
         diff[i] = {meas_ff[i][POS_WIDTH-1], meas_ff[i]} - {est_ff[i][POS_WIDTH-1], est_ff[i]};
         mag[i]  = diff[i][DIFF_W-1] ? DIFF_W'(-diff[i]) : diff[i];
         if (mag[i] > DIFF_W'(reject_ff)) begin
            outlier = 1'b1;
         end
      end
   end

   // Gain divider
   assign prior_sum = PRIOR_W'(var_ff) + PRIOR_W'(drift_ff);
   assign den_sum   = DEN_W'(prior_sum) + DEN_W'(sensor_ff);

   gkps_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.start),
      .num   (prior_sum),
      .den   (den_sum),
      .busy  (div_busy),
      .quot  (gain)
   );

   // Shared multiplier operands
   always_comb begin
      case (cmd.sel)
         SEL_X: begin
            mag_sel = mag[0];
            neg_sel = diff[0][DIFF_W-1];
            est_sel = est_ff[0];
         end
         SEL_Y: begin
            mag_sel = mag[1];
            neg_sel = diff[1][DIFF_W-1];
            est_sel = est_ff[1];
         end
         SEL_Z: begin
            mag_sel = mag[2];
            neg_sel = diff[2][DIFF_W-1];
            est_sel = est_ff[2];
         end
         default: begin
            mag_sel = '0;
            neg_sel = 1'b0;
            est_sel = '0;
         end
      endcase
      if (cmd.sel == SEL_VAR) begin
         mul_a = prior_ff;
         mul_b = (GAIN_W'(1) << GAIN_FRAC_BITS) - gain;
      end else begin
         mul_a = PRIOR_W'(mag_sel);
         mul_b = gain;
      end
   end

   // Round the scaled step, truncate the new variance with saturation
   always_comb begin
      rounded = prod_ff + (PROD_W'(1) << (GAIN_FRAC_BITS - 1));
      step    = DIFF_W'(rounded >> GAIN_FRAC_BITS);
      est_upd = neg_sel ? POS_WIDTH'(est_sel - POS_WIDTH'(step))
                        : POS_WIDTH'(est_sel + POS_WIDTH'(step));
      nv      = NV_W'(prod_ff >> GAIN_FRAC_BITS);
   end

   // Filter state next values
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         est_in[i] = est_ff[i];
      end
      var_in    = var_ff;
      primed_in = primed_ff;
      if (cmd.clear) begin
         for (int i = 0; i < AXES; i++) begin
            est_in[i] = '0;
         end
         var_in    = '0;
         primed_in = 1'b0;
      end else if (cmd.load) begin
         for (int i = 0; i < AXES; i++) begin
            est_in[i] = meas_ff[i];
         end
         var_in    = VAR_W'(sensor_ff);
         primed_in = 1'b1;
      end else if (cmd.apply) begin
         case (cmd.sel)
            SEL_X:   est_in[0] = est_upd;
            SEL_Y:   est_in[1] = est_upd;
            SEL_Z:   est_in[2] = est_upd;
            default: var_in = (|nv[NV_W-1:VAR_W]) ? '1 : VAR_W'(nv);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff <= 1'b0;
         var_ff    <= '0;
         for (int i = 0; i < AXES; i++) begin
            est_ff[i] <= '0;
         end
      end else begin
         primed_ff <= primed_in;
         var_ff    <= var_in;
         for (int i = 0; i < AXES; i++) begin
            est_ff[i] <= est_in[i];
         end
      end
   end

   // Capture the item, the prior and the product
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         is_reset_ff <= req_tuser[0];
         for (int i = 0; i < AXES; i++) begin
            meas_ff[i] <= req_tdata[i*POS_WIDTH +: POS_WIDTH];
         end
      end
      if (cmd.start) begin
         prior_ff <= prior_sum;
      end
      if (cmd.mul) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   // Result register: hold until the transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.write) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.write) begin
         rsp_status_ff <= cmd.status;
         for (int i = 0; i < AXES; i++) begin
            rsp_pos_ff[i] <= (cmd.status == RSP_SMOOTH) ? est_ff[i] : '0;
         end
      end
   end

   always_comb begin
      rsp_tdata = '0;
      for (int i = 0; i < AXES; i++) begin
         rsp_tdata[i*POS_WIDTH +: POS_WIDTH] = rsp_pos_ff[i];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;

   assign status.is_reset = is_reset_ff;
   assign status.primed   = primed_ff;
   assign status.outlier  = outlier;
   assign status.div_busy = div_busy;
   assign status.rsp_free = !rsp_valid_ff || rsp_tready;

endmodule
`default_nettype wire

/* rtl/gkps_ctrl.sv */
`default_nettype none
module gkps_ctrl
   import gkps_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   state_type      state_ff, state_in;
   logic [1:0]     sel_ff, sel_in;
   rsp_status_type code_ff, code_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= SEL_X;
         code_ff  <= RSP_SMOOTH;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
         code_ff  <= code_in;
      end
   end

   // Sequence one item: gate, divide, four multiply and apply passes, write out
   always_comb begin
      state_in   = state_ff;
      sel_in     = sel_ff;
      code_in    = code_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.sel    = sel_ff;
      cmd.status = code_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.is_reset) begin
               cmd.clear = 1'b1;
               code_in   = RSP_RESET;
               state_in  = ST_OUT;
            end else if (!status.primed) begin
               cmd.load = 1'b1;
               code_in  = RSP_SMOOTH;
               state_in = ST_OUT;
            end else if (status.outlier) begin
               code_in  = RSP_OUTLIER;
               state_in = ST_OUT;
            end else begin
               cmd.start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!status.div_busy) begin
               sel_in   = SEL_X;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            if (sel_ff == SEL_VAR) begin
               code_in  = RSP_SMOOTH;
               state_in = ST_OUT;
            end else begin
               sel_in   = sel_ff + 2'd1;
               state_in = ST_MUL;
            end
         end
         ST_OUT: begin
            if (status.rsp_free) begin
               cmd.write = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

/* rtl/gated_kalman_position_smoother_unit.sv */
`default_nettype none
// A filtered measurement passes through the gate, the 25-step restoring gain divider and four
// passes through the shared multiplier before its result is written; a reset command, an outlier
// or the first measurement after reset is answered straight after the gate. A new item is taken
// only once the previous result is written, and that write waits while the output is held.
// Reset (synchronous, active high) clears the filter to unprimed and loads the register defaults.
module gated_kalman_position_smoother_unit
   import gkps_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [TDATA_W-1:0]     req_tdata,  // meas_x, meas_y, meas_z
   input  wire logic [0:0]             req_tuser,  // cmd
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [TDATA_W-1:0]          rsp_tdata,  // smooth_x, smooth_y, smooth_z
   output logic [1:0]                  rsp_tuser,  // status
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   gkps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   gkps_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .status     (status)
   );

endmodule
`default_nettype wire
